@@ rtl/lps_pkg.sv @@
package lps_pkg;

    typedef enum logic [1:0] {
        ST_INACTIVE   = 2'd0,
        ST_SEND_DELAY = 2'd1,
        ST_WAIT       = 2'd2,
        ST_CONFIRMED  = 2'd3
    } t_port_state;

    typedef enum logic [1:0] {
        EV_UP      = 2'd0,
        EV_DOWN    = 2'd1,
        EV_TIMEOUT = 2'd2,
        EV_RECV    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REP_UP       = 2'd0,
        REP_DOWN     = 2'd1,
        REP_UNSTABLE = 2'd2
    } t_report;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_IDLE  = 2'd1,
        BK_EXEC  = 2'd2
    } t_back_state;

    // Timer delays in ms
    localparam logic [14:0] DLY_CONFIRM     = 15'd30000;
    localparam logic [14:0] DLY_SHORT_BASE  = 15'd2000;
    localparam logic [14:0] DLY_LONG_BASE   = 15'd4000;
    localparam logic [14:0] DLY_LAST_SHORT  = 15'd8000;
    localparam logic [14:0] DLY_LAST_LONG   = 15'd16000;
    localparam logic [26:0] SPAN_SHORT      = 27'd2000;
    localparam logic [27:0] SPAN_LONG       = 28'd4000;

    // Retry counts
    localparam logic [3:0] RETRY_ONE     = 4'd1;
    localparam logic [3:0] RETRY_WAIT    = 4'd2;
    localparam logic [3:0] RETRY_REFUSED = 4'd12;
    localparam logic [3:0] RETRY_MAX     = 4'd15;

    typedef struct packed {
        t_action     action;
        logic [5:0]  port_index;
        logic [31:0] now_ms;
        logic [15:0] rand_frac;
        logic [63:0] peer_node;
        logic [15:0] peer_port;
        logic        send_ok;
        logic        report_ok;
        logic        peer_present;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  port_echo;
        t_port_state new_state;
        logic        timer_armed;
        logic [14:0] delay_ms;
        logic        send_probe;
        logic        report_valid;
        t_report     report_status;
        logic [63:0] report_peer_node;
        logic [15:0] report_peer_port;
        logic [3:0]  retry_left;
    } t_out_item;

    // Classified item held between front and back
    typedef struct packed {
        t_action     action;
        logic [5:0]  port_index;
        logic        in_range;
        logic [31:0] now_ms;
        logic [10:0] jit_short;   // (2000 * frac) >> 16
        logic [11:0] jit_long;    // (4000 * frac) >> 16
        logic [63:0] peer_node;
        logic [15:0] peer_port;
        logic        send_ok;
        logic        report_ok;
        logic        peer_present;
    } t_cls_item;

    typedef struct packed {
        t_port_state state;
        logic [3:0]  retry;
        logic        link_up;
        logic [63:0] node;
        logic [15:0] port;
        logic [31:0] sent_time;
    } t_entry;

endpackage

@@ rtl/lps_fifo.sv @@
// Small register FIFO; DEPTH must be a power of two.
module lps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

@@ rtl/lps_front.sv @@
// Accept events, range-check the port, precompute jitter terms, queue.
module lps_front #(
    parameter int PORTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lps_pkg::t_in_item i_item,
    input  logic              i_hold,
    output logic              o_full,
    input  logic              i_cls_pop,
    output lps_pkg::t_cls_item o_cls,
    output logic              o_cls_empty
);
    lps_pkg::t_cls_item cls;
    logic [26:0]        prod_short;
    logic [27:0]        prod_long;
    logic               q_full;
    logic [$bits(lps_pkg::t_cls_item)-1:0] q_out;

    always_comb begin
        prod_short       = 27'(i_item.rand_frac) * lps_pkg::SPAN_SHORT;
        prod_long        = 28'(i_item.rand_frac) * lps_pkg::SPAN_LONG;
        cls.action       = i_item.action;
        cls.port_index   = i_item.port_index;
        cls.in_range     = (32'(i_item.port_index) < 32'(PORTS));
        cls.now_ms       = i_item.now_ms;
        cls.jit_short    = prod_short[26:16];
        cls.jit_long     = prod_long[27:16];
        cls.peer_node    = i_item.peer_node;
        cls.peer_port    = i_item.peer_port;
        cls.send_ok      = i_item.send_ok;
        cls.report_ok    = i_item.report_ok;
        cls.peer_present = i_item.peer_present;
    end

    // Hold off input while the table clear runs
    assign o_full = q_full || i_hold;

    lps_fifo #(
        .WIDTH($bits(lps_pkg::t_cls_item)),
        .DEPTH(2)
    ) u_cls_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_push && !o_full),
        .i_data (cls),
        .i_pop  (i_cls_pop),
        .o_data (q_out),
        .o_full (q_full),
        .o_empty(o_cls_empty)
    );

    assign o_cls = lps_pkg::t_cls_item'(q_out);
endmodule

@@ rtl/lps_back.sv @@
// Port table and per-port probe state machine: read entry, then update.
module lps_back #(
    parameter int PORTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lps_pkg::t_cls_item i_cls,
    input  logic               i_cls_empty,
    output logic               o_cls_pop,
    input  logic               i_res_full,
    output logic               o_res_push,
    output lps_pkg::t_out_item o_res,
    output logic               o_clearing
);
    localparam int IDX_W = $clog2(PORTS);

    lps_pkg::t_entry     r_mem [PORTS];
    lps_pkg::t_entry     r_rd_entry;
    lps_pkg::t_cls_item  r_item;
    lps_pkg::t_back_state r_state;
    lps_pkg::t_back_state n_state;
    logic [IDX_W-1:0]    r_clr_idx;
    logic [IDX_W-1:0]    n_clr_idx;
    logic [31:0]         r_last_up;
    logic [31:0]         n_last_up;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    lps_pkg::t_entry     mem_wdata;
    lps_pkg::t_entry     upd;
    lps_pkg::t_out_item  res;
    logic                last_up_we;

    // Next-state and sequencing
    always_comb begin
        n_state    = r_state;
        n_clr_idx  = r_clr_idx;
        o_cls_pop  = 1'b0;
        o_res_push = 1'b0;
        o_clearing = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_clr_idx;
        mem_wdata  = '0;
        n_last_up  = r_last_up;
        case (r_state)
            lps_pkg::BK_CLEAR: begin
                o_clearing = 1'b1;
                mem_we     = 1'b1;
                if (r_clr_idx == IDX_W'(PORTS - 1)) begin
                    n_state = lps_pkg::BK_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + 1'b1;
                end
            end
            lps_pkg::BK_IDLE: begin
                // Start only with room for the result, so EXEC never stalls
                if (!i_cls_empty && !i_res_full) begin
                    o_cls_pop = 1'b1;
                    n_state   = lps_pkg::BK_EXEC;
                end
            end
            lps_pkg::BK_EXEC: begin
                o_res_push = 1'b1;
                mem_we     = r_item.in_range;
                mem_waddr  = IDX_W'(r_item.port_index);
                mem_wdata  = upd;
                if (last_up_we) begin
                    n_last_up = r_item.now_ms;
                end
                n_state = lps_pkg::BK_IDLE;
            end
            default: begin
                n_state = lps_pkg::BK_IDLE;
            end
        endcase
    end

    // Event evaluation on the fetched entry
    always_comb begin
        logic [14:0] dly;
        logic        armed;
        logic        send;
        logic        more;
        logic        changed;
        logic [14:0] jit_s;
        logic [14:0] jit_l;

        upd        = r_rd_entry;
        dly        = '0;
        armed      = 1'b0;
        send       = 1'b0;
        more       = 1'b0;
        changed    = 1'b0;
        last_up_we = 1'b0;
        jit_s      = 15'(r_item.jit_short);
        jit_l      = 15'(r_item.jit_long);
        res        = '0;
        res.report_status = lps_pkg::REP_UP;

        case (r_rd_entry.state)
            lps_pkg::ST_INACTIVE: begin
                if (r_item.action == lps_pkg::EV_UP) begin
                    upd.state  = lps_pkg::ST_SEND_DELAY;
                    upd.retry  = lps_pkg::RETRY_ONE;
                    armed      = 1'b1;
                    dly        = jit_s;
                    last_up_we = 1'b1;
                end
            end
            lps_pkg::ST_SEND_DELAY: begin
                if (r_item.action == lps_pkg::EV_DOWN) begin
                    upd.state = lps_pkg::ST_INACTIVE;
                    upd.retry = lps_pkg::RETRY_ONE;
                end else if (r_item.action == lps_pkg::EV_TIMEOUT) begin
                    armed = 1'b1;
                    send  = 1'b1;
                end
            end
            lps_pkg::ST_WAIT: begin
                if (r_item.action == lps_pkg::EV_DOWN) begin
                    upd.state = lps_pkg::ST_INACTIVE;
                    upd.retry = lps_pkg::RETRY_ONE;
                end else if (r_item.action == lps_pkg::EV_RECV) begin
                    upd.state        = lps_pkg::ST_CONFIRMED;
                    upd.retry        = r_item.report_ok ? lps_pkg::RETRY_WAIT
                                                        : lps_pkg::RETRY_REFUSED;
                    upd.node         = r_item.peer_node;
                    upd.port         = r_item.peer_port;
                    upd.link_up      = 1'b1;
                    armed            = 1'b1;
                    dly              = lps_pkg::DLY_CONFIRM;
                    res.report_valid = 1'b1;
                    res.report_status    = lps_pkg::REP_UP;
                    res.report_peer_node = r_item.peer_node;
                    res.report_peer_port = r_item.peer_port;
                end else if (r_item.action == lps_pkg::EV_TIMEOUT) begin
                    armed = 1'b1;
                    // Count down with a floor at zero
                    if (r_rd_entry.retry != '0) begin
                        upd.retry = r_rd_entry.retry - 1'b1;
                        more      = (upd.retry != '0);
                    end
                    if (more) begin
                        send = 1'b1;
                    end else begin
                        upd.state        = lps_pkg::ST_CONFIRMED;
                        upd.retry        = r_item.report_ok ? lps_pkg::RETRY_WAIT
                                                            : lps_pkg::RETRY_REFUSED;
                        upd.sent_time    = r_item.now_ms;
                        upd.node         = '0;
                        upd.port         = '0;
                        upd.link_up      = 1'b0;
                        dly              = lps_pkg::DLY_CONFIRM;
                        res.report_valid = 1'b1;
                        res.report_status    = r_rd_entry.link_up ? lps_pkg::REP_UNSTABLE
                                                                  : lps_pkg::REP_DOWN;
                        res.report_peer_node = r_rd_entry.node;
                        res.report_peer_port = r_rd_entry.port;
                    end
                end
            end
            default: begin
                if (r_item.action == lps_pkg::EV_DOWN) begin
                    upd.state = lps_pkg::ST_INACTIVE;
                    upd.retry = lps_pkg::RETRY_ONE;
                end else if (r_item.action == lps_pkg::EV_TIMEOUT) begin
                    armed = 1'b1;
                    if (r_rd_entry.retry != '0) begin
                        upd.retry = r_rd_entry.retry - 1'b1;
                        more      = (upd.retry != '0);
                    end
                    if (r_rd_entry.link_up) begin
                        changed = !r_item.peer_present;
                    end else begin
                        changed = (r_last_up > r_rd_entry.sent_time);
                    end
                    if (more && !changed) begin
                        dly = lps_pkg::DLY_CONFIRM;
                    end else begin
                        upd.state = lps_pkg::ST_SEND_DELAY;
                        upd.retry = lps_pkg::RETRY_ONE;
                        dly       = jit_s;
                    end
                end else if (r_item.action == lps_pkg::EV_RECV && !r_rd_entry.link_up) begin
                    armed            = 1'b1;
                    dly              = lps_pkg::DLY_CONFIRM;
                    res.report_valid = 1'b1;
                    res.report_status    = lps_pkg::REP_UNSTABLE;
                    res.report_peer_node = r_item.peer_node;
                    res.report_peer_port = r_item.peer_port;
                end
            end
        endcase

        // Enter or stay in wait and transmit a probe
        if (send) begin
            if (r_rd_entry.state != lps_pkg::ST_WAIT) begin
                upd.state = lps_pkg::ST_WAIT;
                upd.retry = lps_pkg::RETRY_WAIT;
            end
            if (r_item.send_ok) begin
                upd.sent_time = r_item.now_ms;
                dly = (upd.retry > 4'd1) ? lps_pkg::DLY_SHORT_BASE + jit_s
                                         : lps_pkg::DLY_LAST_SHORT;
            end else begin
                if (upd.retry < lps_pkg::RETRY_MAX) begin
                    upd.retry = upd.retry + 1'b1;
                end
                dly = (upd.retry > 4'd1) ? lps_pkg::DLY_LONG_BASE + jit_l
                                         : lps_pkg::DLY_LAST_LONG;
            end
        end

        res.new_state   = upd.state;
        res.timer_armed = armed;
        res.delay_ms    = dly;
        res.send_probe  = send;
        res.retry_left  = upd.retry;

        // Out-of-range port: echo only, leave the table alone
        if (!r_item.in_range) begin
            res        = '0;
            last_up_we = 1'b0;
        end
        res.port_echo = r_item.port_index;
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lps_pkg::BK_CLEAR;
            r_clr_idx <= '0;
            r_last_up <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_last_up <= n_last_up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cls_pop) begin
            r_item <= i_cls;
        end
    end

    // Port table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_entry <= r_mem[IDX_W'(i_cls.port_index)];
    end

    a_pop_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cls_pop |=> o_res_push && o_res.port_echo == $past(i_cls.port_index))
        else $error("dequeued item did not give its result next cycle");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into full queue");

    a_no_pop_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clearing |-> !o_cls_pop && !o_res_push)
        else $error("item handled during table clear");

    a_out_of_range_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push && !r_item.in_range |->
            !o_res.timer_armed && !o_res.report_valid && o_res.retry_left == 4'd0)
        else $error("out-of-range port produced a non-blank result");
endmodule

@@ rtl/link_probe_state_machine_unit.sv @@
// Channel   Handshake          Payload            Direction
// event     push / full        i_item (t_in_item)   in
// result    pop  / empty       o_result (t_out_item) out
//
// In the back end, IDLE reads each event's port entry from the port table
// and EXEC evaluates and writes it back; the next entry is read only after
// that write, so the back end takes no new item before it is through with the
// last one. After reset the port table is cleared one entry per cycle, with
// full held high; a result shows on the result ports once its item has passed
// the event queue, the IDLE and EXEC states and the result queue.
// A 2-entry event queue and a 2-entry result queue let each side stall alone.
module link_probe_state_machine_unit #(
    parameter int PORTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  lps_pkg::t_in_item   i_item,
    input  logic                pop,
    output logic                empty,
    output lps_pkg::t_out_item  o_result
);
    lps_pkg::t_cls_item cls;
    logic               cls_empty;
    logic               cls_pop;
    logic               clearing;
    logic               res_full;
    logic               res_push;
    lps_pkg::t_out_item res;
    logic [$bits(lps_pkg::t_out_item)-1:0] res_q;

    // Front: accept, classify, queue events
    lps_front #(
        .PORTS(PORTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .i_hold     (clearing),
        .o_full     (full),
        .i_cls_pop  (cls_pop),
        .o_cls      (cls),
        .o_cls_empty(cls_empty)
    );

    // Back: port table read-modify-write
    lps_back #(
        .PORTS(PORTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cls      (cls),
        .i_cls_empty(cls_empty),
        .o_cls_pop  (cls_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res),
        .o_clearing (clearing)
    );

    // Result queue: hold finished items until popped
    lps_fifo #(
        .WIDTH($bits(lps_pkg::t_out_item)),
        .DEPTH(2)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res),
        .i_pop  (pop),
        .o_data (res_q),
        .o_full (res_full),
        .o_empty(empty)
    );

    assign o_result = lps_pkg::t_out_item'(res_q);
endmodule
